/* design/ckc_pkg.sv */
// Package for the cubic klm coordinate block: widths, codes, stage records
// and small arithmetic helpers. No dependencies.
`default_nettype none

package ckc_pkg;

    localparam int COORD_BITS = 16;
    localparam int NORM_BITS  = 16;

    localparam int CW   = COORD_BITS;
    localparam int CXW  = CW + 4;                  // power basis terms
    localparam int PW   = 2 * CXW;                 // cross product halves
    localparam int DW   = PW + 1;                  // d1, d2, d3
    localparam int NW   = NORM_BITS;
    localparam int ZT_W = 38;
    localparam int DT_W = 32;
    localparam int CFG_W = 38;
    localparam int CFG_IDX_W = 2;
    localparam int ZCW  = (DW > ZT_W) ? DW : ZT_W;
    localparam int SW   = $clog2(DW + 1);
    localparam int DIS_W = 2 * NW + 3;
    localparam int DCMP_W = ((DIS_W > DT_W + 1) ? DIS_W : DT_W + 1) + 1;
    localparam int SQ_STAGES = (NW + 2) / 2;
    localparam int SQ_STEPS  = 2 * SQ_STAGES;
    localparam int SQ_W  = 2 * SQ_STEPS;
    localparam int SQS_W = $clog2(SQ_W);
    localparam int RW    = SQ_STEPS;
    localparam int INV_W = 16;
    localparam int RQ_W  = RW + INV_W;
    localparam int AW    = NW + 3;
    localparam int P2W   = 2 * AW;
    localparam int P3W   = 3 * AW;
    localparam int OW    = 60;
    localparam int IN_W     = 8 * CW;
    localparam int IN_TD_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_DW   = 2 + 3 * OW;
    localparam int OUT_TD_W = ((OUT_DW + 7) / 8) * 8;
    localparam int TU_W     = 4;

    localparam logic [INV_W-1:0] INV_SQRT3 = 16'd37837;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCR_THR = 2'd1;

    typedef enum logic [2:0] {
        CLS_SERP     = 3'd0,
        CLS_LOOP     = 3'd1,
        CLS_CUSP_INF = 3'd2,
        CLS_QUAD     = 3'd3,
        CLS_DEGEN    = 3'd4
    } cls_t;

    typedef logic signed [CW-1:0]  crd_t;
    typedef logic signed [NW-1:0]  nrm_t;
    typedef logic signed [AW-1:0]  aw_t;
    typedef logic signed [P2W-1:0] p2_t;
    typedef logic signed [P3W-1:0] p3_t;
    typedef logic signed [OW-1:0]  ow_t;

    localparam ow_t QUAD_K [4] = '{ow_t'(0), ow_t'(1), ow_t'(2), ow_t'(3)};
    localparam ow_t QUAD_L [4] = '{ow_t'(0), ow_t'(0), ow_t'(1), ow_t'(3)};

    typedef struct packed {
        crd_t p3_y;
        crd_t p3_x;
        crd_t p2_y;
        crd_t p2_x;
        crd_t p1_y;
        crd_t p1_x;
        crd_t p0_y;
        crd_t p0_x;
    } ckc_points_t;

    typedef struct packed {
        cls_t cls;
        logic d1neg;
        logic d3neg;
        nrm_t n1;
        nrm_t n2;
        nrm_t n3;
        logic [SQ_W-1:0] rad;
    } ckc_cls_t;

    typedef struct packed {
        cls_t cls;
        logic d1neg;
        logic d3neg;
    } ckc_tag_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
    } ckc_root_t;

    typedef struct packed {
        cls_t cls;
        logic [3:0][OW-1:0] k;
        logic [3:0][OW-1:0] l;
        logic [3:0][OW-1:0] m;
    } ckc_res_t;

    // one step of the digit-by-digit square root
    function automatic ckc_root_t sqrt_step(input ckc_root_t x, input logic [SQS_W-1:0] sh);
        ckc_root_t y;
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] trial;
        y = x;
        bitv = SQ_W'(1) << sh;
        trial = x.res + bitv;
        if (x.rem >= trial)
        begin
            y.rem = x.rem - trial;
            y.res = (x.res >> 1) + bitv;
        end
        else
        begin
            y.res = x.res >> 1;
        end
        return y;
    endfunction

    function automatic ow_t times3(input ow_t v);
        return (v <<< 1) + v;
    endfunction

    // power basis column to scaled Bezier values
    function automatic logic [3:0][OW-1:0] to_bezier(input ow_t f0, input ow_t f1,
                                                     input ow_t f2, input ow_t f3);
        logic [3:0][OW-1:0] o;
        o[0] = times3(f0);
        o[1] = times3(f0) + f1;
        o[2] = times3(f0) + (f1 <<< 1) + f2;
        o[3] = times3(f0 + f1 + f2 + f3);
        return o;
    endfunction

endpackage

`default_nettype wire

/* design/ckc_front.sv */
// Front pipeline: power basis, cross products, d1..d3, zero tests, common
// normalising shift, discriminant and classification. Uses ckc_pkg.
`default_nettype none

module ckc_front
    import ckc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire ckc_points_t       pts,
    input  wire logic [ZT_W-1:0]   zero_threshold,
    input  wire logic [DT_W-1:0]   discr_threshold,
    output logic                   out_valid,
    output ckc_cls_t               out_cls
);

    typedef logic signed [CXW-1:0]    cx_t;
    typedef logic signed [PW-1:0]     pw_t;
    typedef logic signed [DW-1:0]     dw_t;
    typedef logic signed [2*NW-1:0]   sq_t;
    typedef logic signed [DIS_W-1:0]  dis_t;
    typedef logic signed [DCMP_W-1:0] cmp_t;

    function automatic logic [DW-1:0] mag(input dw_t v);
        return v[DW-1] ? DW'(-v) : DW'(v);
    endfunction

    logic [6:0] vld_reg;

    cx_t c1x_reg, c1y_reg, c2x_reg, c2y_reg, c3x_reg, c3y_reg;
    cx_t c1x_next, c1y_next, c2x_next, c2y_next, c3x_next, c3y_next;
    pw_t m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    dw_t d1_reg, d2_reg, d3_reg;
    dw_t d1_4_reg, d2_4_reg, d3_4_reg;
    logic [2:0] z4_reg, z4_next;
    logic [SW-1:0] s_reg, s_next;
    nrm_t n1_reg, n2_reg, n3_reg;
    logic [2:0] z5_reg;
    logic [1:0] neg5_reg;
    sq_t sq_reg, pq_reg;
    nrm_t n1_6_reg, n2_6_reg, n3_6_reg;
    logic [2:0] z6_reg;
    logic [1:0] neg6_reg;
    ckc_cls_t out_reg, out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[5:0], in_valid};
    end

    // power basis
    always_comb
    begin
        c1x_next = cx_t'(pts.p1_x) - cx_t'(pts.p0_x);
        c1x_next = (c1x_next <<< 1) + c1x_next;
        c1y_next = cx_t'(pts.p1_y) - cx_t'(pts.p0_y);
        c1y_next = (c1y_next <<< 1) + c1y_next;
        c2x_next = cx_t'(pts.p0_x) - (cx_t'(pts.p1_x) <<< 1) + cx_t'(pts.p2_x);
        c2x_next = (c2x_next <<< 1) + c2x_next;
        c2y_next = cx_t'(pts.p0_y) - (cx_t'(pts.p1_y) <<< 1) + cx_t'(pts.p2_y);
        c2y_next = (c2y_next <<< 1) + c2y_next;
        c3x_next = cx_t'(pts.p1_x) - cx_t'(pts.p2_x);
        c3x_next = (c3x_next <<< 1) + c3x_next + cx_t'(pts.p3_x) - cx_t'(pts.p0_x);
        c3y_next = cx_t'(pts.p1_y) - cx_t'(pts.p2_y);
        c3y_next = (c3y_next <<< 1) + c3y_next + cx_t'(pts.p3_y) - cx_t'(pts.p0_y);
    end

    // zero tests and the smallest shift that brings all three into range
    always_comb
    begin
        logic [DW-1:0] mm;
        logic [SW-1:0] blen;
        z4_next[0] = ZCW'(mag(d1_reg)) <= ZCW'(zero_threshold);
        z4_next[1] = ZCW'(mag(d2_reg)) <= ZCW'(zero_threshold);
        z4_next[2] = ZCW'(mag(d3_reg)) <= ZCW'(zero_threshold);
        mm = (d1_reg[DW-1] ? DW'(~d1_reg) : DW'(d1_reg))
           | (d2_reg[DW-1] ? DW'(~d2_reg) : DW'(d2_reg))
           | (d3_reg[DW-1] ? DW'(~d3_reg) : DW'(d3_reg));
        blen = '0;
        for (int i = 0; i < DW; i++)
        begin
            if (mm[i])
                blen = SW'(i + 1);
        end
        s_next = (blen > SW'(NW - 1)) ? blen - SW'(NW - 1) : '0;
    end

    // discriminant and class
    always_comb
    begin
        dis_t dis;
        dis = (dis_t'(sq_reg) <<< 1) + dis_t'(sq_reg) - (dis_t'(pq_reg) <<< 2);
        out_next.d1neg = neg6_reg[0];
        out_next.d3neg = neg6_reg[1];
        out_next.n1 = n1_6_reg;
        out_next.n2 = n2_6_reg;
        out_next.n3 = n3_6_reg;
        out_next.rad = '0;
        priority if (&z6_reg)
            out_next.cls = CLS_DEGEN;
        else if (z6_reg[0] && z6_reg[1])
            out_next.cls = CLS_QUAD;
        else if (z6_reg[0])
            out_next.cls = CLS_CUSP_INF;
        else if (cmp_t'(dis) < -cmp_t'(discr_threshold))
        begin
            out_next.cls = CLS_LOOP;
            out_next.rad = SQ_W'(-dis);
        end
        else
        begin
            out_next.cls = CLS_SERP;
            out_next.rad = dis[DIS_W-1] ? '0 : SQ_W'(dis);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1x_reg <= c1x_next;
            c1y_reg <= c1y_next;
            c2x_reg <= c2x_next;
            c2y_reg <= c2y_next;
            c3x_reg <= c3x_next;
            c3y_reg <= c3y_next;
            m0_reg <= pw_t'(c2x_reg) * pw_t'(c3y_reg);
            m1_reg <= pw_t'(c2y_reg) * pw_t'(c3x_reg);
            m2_reg <= pw_t'(c1x_reg) * pw_t'(c3y_reg);
            m3_reg <= pw_t'(c1y_reg) * pw_t'(c3x_reg);
            m4_reg <= pw_t'(c1x_reg) * pw_t'(c2y_reg);
            m5_reg <= pw_t'(c1y_reg) * pw_t'(c2x_reg);
            d1_reg <= dw_t'(m1_reg) - dw_t'(m0_reg);
            d2_reg <= dw_t'(m2_reg) - dw_t'(m3_reg);
            d3_reg <= dw_t'(m5_reg) - dw_t'(m4_reg);
            d1_4_reg <= d1_reg;
            d2_4_reg <= d2_reg;
            d3_4_reg <= d3_reg;
            z4_reg <= z4_next;
            s_reg <= s_next;
            n1_reg <= nrm_t'(d1_4_reg >>> s_reg);
            n2_reg <= nrm_t'(d2_4_reg >>> s_reg);
            n3_reg <= nrm_t'(d3_4_reg >>> s_reg);
            z5_reg <= z4_reg;
            neg5_reg <= {d3_4_reg[DW-1], d1_4_reg[DW-1]};
            sq_reg <= sq_t'(n2_reg) * sq_t'(n2_reg);
            pq_reg <= sq_t'(n1_reg) * sq_t'(n3_reg);
            n1_6_reg <= n1_reg;
            n2_6_reg <= n2_reg;
            n3_6_reg <= n3_reg;
            z6_reg <= z5_reg;
            neg6_reg <= neg5_reg;
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[6];
    assign out_cls   = out_reg;

endmodule

`default_nettype wire

/* design/ckc_sqrt.sv */
// Pipelined floor square root of the discriminant magnitude, two result
// bits per stage; carries the class record alongside. Uses ckc_pkg.
`default_nettype none

module ckc_sqrt
    import ckc_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire ckc_cls_t       in_cls,
    output logic                out_valid,
    output ckc_cls_t            out_cls,
    output logic [RW-1:0]       out_root
);

    logic [SQ_STAGES-1:0] vld_reg;
    ckc_root_t root_reg [SQ_STAGES];
    ckc_root_t root_next [SQ_STAGES];
    ckc_cls_t  info_reg [SQ_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[SQ_STAGES-2:0], in_valid};
    end

    always_comb
    begin
        ckc_root_t src;
        for (int g = 0; g < SQ_STAGES; g++)
        begin
            if (g == 0)
            begin
                src.rem = in_cls.rad;
                src.res = '0;
            end
            else
            begin
                src = root_reg[g-1];
            end
            root_next[g] = sqrt_step(sqrt_step(src, SQS_W'(SQ_W - 2 - 4 * g)),
                                     SQS_W'(SQ_W - 4 - 4 * g));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            info_reg[0] <= in_cls;
            for (int g = 0; g < SQ_STAGES; g++)
            begin
                root_reg[g] <= root_next[g];
            end
            for (int g = 1; g < SQ_STAGES; g++)
            begin
                info_reg[g] <= info_reg[g-1];
            end
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign out_cls   = info_reg[SQ_STAGES-1];
    assign out_root  = root_reg[SQ_STAGES-1].res[RW-1:0];

endmodule

`default_nettype wire

/* design/ckc_klm.sv */
// klm pipeline: root scaling, factor selection, products, power basis
// columns and Bezier conversion with orientation. Uses ckc_pkg.
`default_nettype none

module ckc_klm
    import ckc_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire ckc_cls_t       in_cls,
    input  wire logic [RW-1:0]  in_root,
    output logic                out_valid,
    output ckc_res_t            out_res
);

    logic [5:0] vld_reg;

    logic [RQ_W-1:0] rq_reg;
    logic [RW-1:0]   r1_reg;
    ckc_tag_t tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    nrm_t n1_1_reg, n2_1_reg, n3_1_reg;
    aw_t a2_reg, b2_reg, s2_reg, a2_next, b2_next, s2_next;
    p2_t aa_reg, bb_reg, ab_reg, sa_reg, sb_reg, ss_reg;
    aw_t a3_reg, b3_reg, s3_reg;
    ow_t aaa_reg, bbb_reg, aab_reg, abb_reg, saa_reg, sbb_reg;
    ow_t sab_reg, ssa_reg, ssb_reg, sss_reg;
    ow_t ab4_reg, sa4_reg, sb4_reg, ss4_reg, a4_reg, s4_reg;
    ow_t kf_reg [4], lf_reg [4], mf_reg [4];
    ow_t kf_next [4], lf_next [4], mf_next [4];
    ckc_res_t res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[4:0], in_valid};
    end

    // pick the factors: serpentine uses r/sqrt3, loop uses r, cusp uses n3
    always_comb
    begin
        logic [RW-1:0] t;
        t = (tag1_reg.cls == CLS_LOOP) ? r1_reg : rq_reg[RQ_W-1:INV_W];
        a2_next = aw_t'(n2_1_reg) + aw_t'(t);
        b2_next = aw_t'(n2_1_reg) - aw_t'(t);
        s2_next = aw_t'(n1_1_reg) <<< 1;
        if (tag1_reg.cls == CLS_CUSP_INF)
        begin
            a2_next = aw_t'(n3_1_reg);
            b2_next = '0;
            s2_next = (aw_t'(n2_1_reg) <<< 1) + aw_t'(n2_1_reg);
        end
    end

    // power basis columns
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            kf_next[i] = '0;
            lf_next[i] = '0;
            mf_next[i] = '0;
        end
        unique case (tag4_reg.cls)
            CLS_SERP, CLS_LOOP:
            begin
                kf_next[0] = ab4_reg;
                kf_next[1] = -(sa4_reg + sb4_reg);
                kf_next[2] = ss4_reg;
                lf_next[3] = -sss_reg;
                mf_next[3] = -sss_reg;
                if (tag4_reg.cls == CLS_SERP)
                begin
                    lf_next[0] = aaa_reg;
                    lf_next[1] = -times3(saa_reg);
                    lf_next[2] = times3(ssa_reg);
                    mf_next[0] = bbb_reg;
                    mf_next[1] = -times3(sbb_reg);
                    mf_next[2] = times3(ssb_reg);
                end
                else
                begin
                    lf_next[0] = aab_reg;
                    lf_next[1] = -(saa_reg + (sab_reg <<< 1));
                    lf_next[2] = ssb_reg + (ssa_reg <<< 1);
                    mf_next[0] = abb_reg;
                    mf_next[1] = -(sbb_reg + (sab_reg <<< 1));
                    mf_next[2] = ssa_reg + (ssb_reg <<< 1);
                end
            end
            CLS_CUSP_INF:
            begin
                kf_next[0] = a4_reg;
                kf_next[1] = -s4_reg;
                lf_next[0] = aaa_reg;
                lf_next[1] = -times3(saa_reg);
                lf_next[2] = times3(ssa_reg);
                lf_next[3] = -sss_reg;
                mf_next[0] = ow_t'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Bezier values, orientation and the fixed quadratic pattern
    always_comb
    begin
        res_next.cls = tag5_reg.cls;
        res_next.k = to_bezier(kf_reg[0], kf_reg[1], kf_reg[2], kf_reg[3]);
        res_next.l = to_bezier(lf_reg[0], lf_reg[1], lf_reg[2], lf_reg[3]);
        res_next.m = to_bezier(mf_reg[0], mf_reg[1], mf_reg[2], mf_reg[3]);
        unique case (tag5_reg.cls)
            CLS_SERP, CLS_LOOP:
            begin
                if (tag5_reg.d1neg)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        res_next.k[i] = -res_next.k[i];
                        res_next.l[i] = -res_next.l[i];
                    end
                end
            end
            CLS_CUSP_INF:
            begin
            end
            CLS_QUAD:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    res_next.k[i] = tag5_reg.d3neg ? -QUAD_K[i] : QUAD_K[i];
                    res_next.l[i] = tag5_reg.d3neg ? -QUAD_L[i] : QUAD_L[i];
                    res_next.m[i] = res_next.k[i];
                end
            end
            default:
            begin
                res_next.k = '0;
                res_next.l = '0;
                res_next.m = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rq_reg   <= RQ_W'(in_root) * RQ_W'(INV_SQRT3);
            r1_reg   <= in_root;
            tag1_reg <= '{cls: in_cls.cls, d1neg: in_cls.d1neg, d3neg: in_cls.d3neg};
            n1_1_reg <= in_cls.n1;
            n2_1_reg <= in_cls.n2;
            n3_1_reg <= in_cls.n3;

            a2_reg   <= a2_next;
            b2_reg   <= b2_next;
            s2_reg   <= s2_next;
            tag2_reg <= tag1_reg;

            aa_reg   <= p2_t'(a2_reg) * p2_t'(a2_reg);
            bb_reg   <= p2_t'(b2_reg) * p2_t'(b2_reg);
            ab_reg   <= p2_t'(a2_reg) * p2_t'(b2_reg);
            sa_reg   <= p2_t'(s2_reg) * p2_t'(a2_reg);
            sb_reg   <= p2_t'(s2_reg) * p2_t'(b2_reg);
            ss_reg   <= p2_t'(s2_reg) * p2_t'(s2_reg);
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            s3_reg   <= s2_reg;
            tag3_reg <= tag2_reg;

            aaa_reg  <= ow_t'(p3_t'(aa_reg) * p3_t'(a3_reg));
            bbb_reg  <= ow_t'(p3_t'(bb_reg) * p3_t'(b3_reg));
            aab_reg  <= ow_t'(p3_t'(aa_reg) * p3_t'(b3_reg));
            abb_reg  <= ow_t'(p3_t'(bb_reg) * p3_t'(a3_reg));
            saa_reg  <= ow_t'(p3_t'(sa_reg) * p3_t'(a3_reg));
            sbb_reg  <= ow_t'(p3_t'(sb_reg) * p3_t'(b3_reg));
            sab_reg  <= ow_t'(p3_t'(sa_reg) * p3_t'(b3_reg));
            ssa_reg  <= ow_t'(p3_t'(ss_reg) * p3_t'(a3_reg));
            ssb_reg  <= ow_t'(p3_t'(ss_reg) * p3_t'(b3_reg));
            sss_reg  <= ow_t'(p3_t'(ss_reg) * p3_t'(s3_reg));
            ab4_reg  <= ow_t'(ab_reg);
            sa4_reg  <= ow_t'(sa_reg);
            sb4_reg  <= ow_t'(sb_reg);
            ss4_reg  <= ow_t'(ss_reg);
            a4_reg   <= ow_t'(a3_reg);
            s4_reg   <= ow_t'(s3_reg);
            tag4_reg <= tag3_reg;

            for (int i = 0; i < 4; i++)
            begin
                kf_reg[i] <= kf_next[i];
                lf_reg[i] <= lf_next[i];
                mf_reg[i] <= mf_next[i];
            end
            tag5_reg <= tag4_reg;

            res_reg  <= res_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_res   = res_reg;

endmodule

`default_nettype wire

/* design/ckc_serial.sv */
// Output stage: holds one curve record and sends its items one vertex per
// cycle while out_ready is high, a single item for a degenerate curve. Uses ckc_pkg.
`default_nettype none

module ckc_serial
    import ckc_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire ckc_res_t        in_res,
    input  wire logic            out_ready,
    output logic                 take,
    output logic                 out_valid,
    output logic [1:0]           vertex_index,
    output logic [OW-1:0]        k_coord,
    output logic [OW-1:0]        l_coord,
    output logic [OW-1:0]        m_coord,
    output cls_t                 curve_class,
    output logic                 coords_valid,
    output logic                 last_of_curve
);

    logic       hold_reg, hold_next;
    logic [1:0] beat_reg, beat_next;
    ckc_res_t   rec_reg;
    logic       last_beat;

    assign last_beat = (rec_reg.cls == CLS_DEGEN) || (beat_reg == 2'd3);
    assign take      = !hold_reg || (out_ready && last_beat);

    always_comb
    begin
        hold_next = hold_reg;
        beat_next = beat_reg;
        if (take)
        begin
            hold_next = in_valid;
            beat_next = '0;
        end
        else if (out_ready)
        begin
            beat_next = beat_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
            beat_reg <= '0;
        end
        else
        begin
            hold_reg <= hold_next;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
            rec_reg <= in_res;
    end

    assign out_valid     = hold_reg;
    assign vertex_index  = beat_reg;
    assign k_coord       = rec_reg.k[beat_reg];
    assign l_coord       = rec_reg.l[beat_reg];
    assign m_coord       = rec_reg.m[beat_reg];
    assign curve_class   = rec_reg.cls;
    assign coords_valid  = (rec_reg.cls != CLS_DEGEN);
    assign last_of_curve = last_beat;

endmodule

`default_nettype wire

/* design/cubic_klm_coordinates.sv */
// Top level of the cubic klm coordinate block: stream ports, configuration
// registers and the pipeline. Uses ckc_pkg, ckc_front, ckc_sqrt, ckc_klm,
// ckc_serial.
//
// Usage: one item on the s_axis channel carries the four control points of a
// cubic (signed Q12.4). The m_axis channel returns one item per control point
// with its klm coordinates times three, the curve class and a valid flag;
// tlast marks the last item of a curve. A degenerate curve gives one item.
// Throughput: the single result channel sends four vertex items per curve;
// degenerate curves pass at one per cycle while m_axis_tready is high. The
// 22-stage pipeline itself takes a new curve every cycle while not stalled.
// Stall: while the output holds a curve that is not fully taken and the last
// pipeline stage is full, the whole pipeline holds and s_axis_tready drops;
// nothing is lost or repeated.
// Reset: pipeline and output empty, both thresholds zero. Write the threshold
// registers through cfg_we/cfg_index/cfg_data only while the block is idle.
`default_nettype none

module cubic_klm_coordinates
    import ckc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
    input  wire logic [IN_TD_W-1:0]    s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // vertex_index, k_coord, l_coord, m_coord, zero pad
    output logic [OUT_TD_W-1:0]        m_axis_tdata,
    // curve_class, coords_valid
    output logic [TU_W-1:0]            m_axis_tuser,
    output logic                       m_axis_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data
);

    logic [ZT_W-1:0] zt_reg;
    logic [DT_W-1:0] dt_reg;
    logic            en;
    logic            take;
    ckc_points_t     pts;
    logic            front_valid, sqrt_valid, klm_valid;
    ckc_cls_t        front_cls, sqrt_cls;
    logic [RW-1:0]   root;
    ckc_res_t        klm_res;
    logic [1:0]      vertex_index;
    logic [OW-1:0]   k_coord, l_coord, m_coord;
    cls_t            curve_class;
    logic            coords_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zt_reg <= '0;
            dt_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ZERO_THR)
                zt_reg <= cfg_data[ZT_W-1:0];
            else if (cfg_index == REG_DISCR_THR)
                dt_reg <= cfg_data[DT_W-1:0];
        end
    end

    // advance the pipeline unless the output keeps its curve and the last stage is full
    assign en            = take || !klm_valid;
    assign s_axis_tready = en;
    assign pts           = s_axis_tdata[IN_W-1:0];

    ckc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (s_axis_tvalid),
        .pts             (pts),
        .zero_threshold  (zt_reg),
        .discr_threshold (dt_reg),
        .out_valid       (front_valid),
        .out_cls         (front_cls)
    );

    ckc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_cls    (front_cls),
        .out_valid (sqrt_valid),
        .out_cls   (sqrt_cls),
        .out_root  (root)
    );

    ckc_klm u_klm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .in_cls    (sqrt_cls),
        .in_root   (root),
        .out_valid (klm_valid),
        .out_res   (klm_res)
    );

    ckc_serial u_serial (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (klm_valid),
        .in_res        (klm_res),
        .out_ready     (m_axis_tready),
        .take          (take),
        .out_valid     (m_axis_tvalid),
        .vertex_index  (vertex_index),
        .k_coord       (k_coord),
        .l_coord       (l_coord),
        .m_coord       (m_coord),
        .curve_class   (curve_class),
        .coords_valid  (coords_valid),
        .last_of_curve (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TD_W'({m_coord, l_coord, k_coord, vertex_index});
    assign m_axis_tuser = {coords_valid, curve_class};

    // a usable curve ends exactly on its fourth vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[3] |-> (m_axis_tlast == (m_axis_tdata[1:0] == 2'd3)))
        else $error("tlast out of step with vertex index");

    // a degenerate curve is a single item for vertex zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[3] |-> m_axis_tlast && (m_axis_tdata[1:0] == 2'd0))
        else $error("degenerate curve not a single item");

    // valid flag follows the class
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[3] == (m_axis_tuser[2:0] != CLS_DEGEN)))
        else $error("coords_valid disagrees with curve class");

    // vertices of one curve follow each other without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && (m_axis_tdata[1:0] == $past(m_axis_tdata[1:0]) + 2'd1))
        else $error("vertex sequence broken");

    // no item enters while the pipeline holds
    assert property (@(posedge clk) disable iff (!rst_n)
        klm_valid && !take |-> !s_axis_tready)
        else $error("input accepted during a stall");

endmodule

`default_nettype wire

/* tb/cubic_klm_coordinates_tb.sv */
// Testbench for cubic_klm_coordinates: drives curves on the input stream and
// checks every vertex item against a built-in klm predictor.
// Depends on ckc_pkg and the RTL of the block.
`default_nettype none

module cubic_klm_coordinates_tb;
    import ckc_pkg::*;

    typedef bit [63:0] col_t [4];

    typedef struct {
        bit [1:0]  vidx;
        bit [59:0] k;
        bit [59:0] l;
        bit [59:0] m;
        cls_t      cls;
        bit        ok;
        bit        last;
    } vertex_t;

    typedef struct {
        int pt [8];
        bit degen;
    } curve_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_TD_W-1:0]   s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_TD_W-1:0]  m_axis_tdata;
    logic [TU_W-1:0]      m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    vertex_t    vertex_q [$];
    int         errors = 0;
    bit [37:0]  zero_thr = 0;
    bit [31:0]  discr_thr = 0;
    bit         no_idle = 0;
    bit         hold_req = 0;

    // degenerate rows get a typed-in result in place of the predicted one, the rest keep the predictor's
    curve_row_t curve_tab [14] = '{
        '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1},
        '{'{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}, 1'b1},
        '{'{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768}, 1'b1},
        '{'{0, 0, 16, 16, 32, 32, 48, 48}, 1'b1},
        '{'{0, 0, 20, 40, 40, 40, 60, 0}, 1'b0},
        '{'{0, 0, 20, -40, 40, -40, 60, 0}, 1'b0},
        '{'{0, 0, 100, 300, 200, -300, 300, 0}, 1'b0},
        '{'{0, 0, 300, 200, -100, 200, 200, 0}, 1'b0},
        '{'{0, 0, 200, 0, 200, 0, 0, 200}, 1'b0},
        '{'{0, 0, 0, 100, 100, 100, 300, 400}, 1'b0},
        '{'{-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767}, 1'b0},
        '{'{32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768}, 1'b0},
        '{'{-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768}, 1'b0},
        '{'{0, 0, 48, 0, 0, 48, 48, 48}, 1'b0}
    };

    cubic_klm_coordinates uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    function automatic bit fits_norm(input longint v);
        return v >= -(longint'(1) <<< (NW - 1)) && v <= (longint'(1) <<< (NW - 1)) - 1;
    endfunction

    function automatic bit [63:0] floor_sqrt(input bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void bezier_col(input bit [63:0] f0, input bit [63:0] f1,
                                       input bit [63:0] f2, input bit [63:0] f3,
                                       output col_t o);
        o[0] = 3 * f0;
        o[1] = 3 * f0 + f1;
        o[2] = 3 * f0 + 2 * f1 + f2;
        o[3] = 3 * (f0 + f1 + f2 + f3);
    endfunction

    function automatic void cubed_col(input bit [63:0] t, input bit [63:0] s, output col_t o);
        bezier_col(t * t * t, 64'd0 - 3 * s * t * t, 3 * s * s * t, 64'd0 - s * s * s, o);
    endfunction

    // work out the vertex items of one curve and queue them
    function automatic void predict_klm(input ckc_points_t p);
        longint x [4];
        longint y [4];
        longint c1x, c1y, c2x, c2y, c3x, c3y, d1, d2, d3, n1, n2, n3, dis, thr, q;
        bit [63:0] a, b, sv, t, sl, r;
        col_t kk, ll, mm;
        bit z1, z2, z3;
        int s;
        cls_t c;
        vertex_t v;
        x[0] = p.p0_x; y[0] = p.p0_y; x[1] = p.p1_x; y[1] = p.p1_y;
        x[2] = p.p2_x; y[2] = p.p2_y; x[3] = p.p3_x; y[3] = p.p3_y;
        c1x = 3 * (x[1] - x[0]);
        c1y = 3 * (y[1] - y[0]);
        c2x = 3 * (x[0] - 2 * x[1] + x[2]);
        c2y = 3 * (y[0] - 2 * y[1] + y[2]);
        c3x = -x[0] + 3 * x[1] - 3 * x[2] + x[3];
        c3y = -y[0] + 3 * y[1] - 3 * y[2] + y[3];
        d1 = -(c2x * c3y - c2y * c3x);
        d2 = c1x * c3y - c1y * c3x;
        d3 = -(c1x * c2y - c1y * c2x);
        z1 = ((d1 < 0) ? -d1 : d1) <= longint'(zero_thr);
        z2 = ((d2 < 0) ? -d2 : d2) <= longint'(zero_thr);
        z3 = ((d3 < 0) ? -d3 : d3) <= longint'(zero_thr);
        s = 0;
        while (s < 63 && !(fits_norm(d1 >>> s) && fits_norm(d2 >>> s) && fits_norm(d3 >>> s)))
            s++;
        n1 = d1 >>> s;
        n2 = d2 >>> s;
        n3 = d3 >>> s;
        if (z1 && z2 && z3)
        begin
            v = '{2'd0, 60'd0, 60'd0, 60'd0, CLS_DEGEN, 1'b0, 1'b1};
            vertex_q = {vertex_q, v};
            return;
        end
        if (z1 && z2)
            c = CLS_QUAD;
        else if (z1)
            c = CLS_CUSP_INF;
        else
        begin
            thr = longint'(discr_thr);
            dis = 3 * n2 * n2 - 4 * n1 * n3;
            c = (dis < -thr) ? CLS_LOOP : CLS_SERP;
        end
        if (c == CLS_QUAD)
        begin
            for (int i = 0; i < 4; i++)
            begin
                kk[i] = (d3 < 0) ? 64'd0 - QUAD_K[i] : 64'(QUAD_K[i]);
                ll[i] = (d3 < 0) ? 64'd0 - QUAD_L[i] : 64'(QUAD_L[i]);
                mm[i] = kk[i];
            end
        end
        else if (c == CLS_CUSP_INF)
        begin
            t = n3;
            sl = 3 * n2;
            bezier_col(t, 64'd0 - sl, 0, 0, kk);
            cubed_col(t, sl, ll);
            bezier_col(1, 0, 0, 0, mm);
        end
        else
        begin
            sv = 2 * n1;
            if (c == CLS_SERP)
            begin
                r = floor_sqrt((dis > 0) ? 64'(dis) : 64'd0);
                q = longint'((r * INV_SQRT3) >> 16);
                a = n2 + q;
                b = n2 - q;
                cubed_col(a, sv, ll);
                cubed_col(b, sv, mm);
            end
            else
            begin
                r = floor_sqrt(64'(-dis));
                a = n2 + longint'(r);
                b = n2 - longint'(r);
                bezier_col(a * a * b, 64'd0 - (sv * a * a + 2 * sv * b * a),
                           b * sv * sv + 2 * sv * a * sv, 64'd0 - sv * sv * sv, ll);
                bezier_col(a * b * b, 64'd0 - (sv * b * b + 2 * sv * a * b),
                           a * sv * sv + 2 * sv * b * sv, 64'd0 - sv * sv * sv, mm);
            end
            bezier_col(a * b, 64'd0 - (sv * a + sv * b), sv * sv, 0, kk);
            // flip orientation for negative d1
            if (d1 < 0)
                for (int i = 0; i < 4; i++)
                begin
                    kk[i] = 64'd0 - kk[i];
                    ll[i] = 64'd0 - ll[i];
                end
        end
        for (int i = 0; i < 4; i++)
        begin
            v = '{2'(i), kk[i][59:0], ll[i][59:0], mm[i][59:0], c, 1'b1, i == 3};
            vertex_q = {vertex_q, v};
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %h, expected %h", what, got, want);
        errors++;
    endtask

    // compare every accepted output item with the oldest expectation
    always @(posedge clk)
    begin
        vertex_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (vertex_q.size() == 0)
                report_mismatch("unexpected item", m_axis_tdata[63:0], 64'd0);
            else
            begin
                w = vertex_q.pop_front();
                if (m_axis_tdata[1:0] !== w.vidx)
                    report_mismatch("vertex_index", m_axis_tdata[1:0], w.vidx);
                if (m_axis_tdata[61:2] !== w.k)
                    report_mismatch("k_coord", m_axis_tdata[61:2], w.k);
                if (m_axis_tdata[121:62] !== w.l)
                    report_mismatch("l_coord", m_axis_tdata[121:62], w.l);
                if (m_axis_tdata[181:122] !== w.m)
                    report_mismatch("m_coord", m_axis_tdata[181:122], w.m);
                if (m_axis_tuser[2:0] !== w.cls)
                    report_mismatch("curve_class", m_axis_tuser[2:0], w.cls);
                if (m_axis_tuser[3] !== w.ok)
                    report_mismatch("coords_valid", m_axis_tuser[3], w.ok);
                if (m_axis_tlast !== w.last)
                    report_mismatch("last_of_curve", m_axis_tlast, w.last);
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                for (n = 0; n < 300; n++)
                    @(negedge clk);
                hold_req = 0;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(negedge clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx == REG_ZERO_THR)
            zero_thr = val;
        else if (idx == REG_DISCR_THR)
            discr_thr = val[31:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // send one curve, with an optional idle burst first
    task automatic send_curve(input ckc_points_t p);
        int gap;
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = p;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_klm(p);
        // leave tvalid high; an idle burst in the next call or the drain lowers it
    endtask

    task automatic drain;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (vertex_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic ckc_points_t random_curve;
        ckc_points_t p;
        int span;
        case ($urandom_range(0, 3))
            0: span = 32767;
            1: span = 2000;
            2: span = 64;
            default: span = 4;
        endcase
        p.p0_x = crd_t'($urandom_range(0, 2 * span) - span);
        p.p0_y = crd_t'($urandom_range(0, 2 * span) - span);
        p.p1_x = crd_t'($urandom_range(0, 2 * span) - span);
        p.p1_y = crd_t'($urandom_range(0, 2 * span) - span);
        p.p2_x = crd_t'($urandom_range(0, 2 * span) - span);
        p.p2_y = crd_t'($urandom_range(0, 2 * span) - span);
        p.p3_x = crd_t'($urandom_range(0, 2 * span) - span);
        p.p3_y = crd_t'($urandom_range(0, 2 * span) - span);
        if (span == 32767 && $urandom_range(0, 1))
            p = {$urandom, $urandom, $urandom, $urandom};
        return p;
    endfunction

    initial
    begin
        ckc_points_t p;
        vertex_t w;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed curves at reset thresholds
        foreach (curve_tab[i])
        begin
            p = {crd_t'(curve_tab[i].pt[7]), crd_t'(curve_tab[i].pt[6]),
                 crd_t'(curve_tab[i].pt[5]), crd_t'(curve_tab[i].pt[4]),
                 crd_t'(curve_tab[i].pt[3]), crd_t'(curve_tab[i].pt[2]),
                 crd_t'(curve_tab[i].pt[1]), crd_t'(curve_tab[i].pt[0])};
            if (curve_tab[i].degen)
            begin
                send_curve(p);
                // replace the predicted item with the typed-in one
                w = '{2'd0, 60'd0, 60'd0, 60'd0, CLS_DEGEN, 1'b0, 1'b1};
                vertex_q[vertex_q.size() - 1] = w;
            end
            else
                send_curve(p);
        end
        drain();

        // write out-of-range register indexes, then set both thresholds to all ones
        write_reg(2'd2, '1);
        write_reg(2'd3, '1);
        write_reg(REG_ZERO_THR, '1);
        write_reg(REG_DISCR_THR, '1);
        for (int i = 5; i < 9; i++)
            send_curve({crd_t'(i * 9), crd_t'(-i), crd_t'(300), crd_t'(i),
                        crd_t'(-200), crd_t'(i * 50), crd_t'(i), crd_t'(0)});
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_ZERO_THR, 0); write_reg(REG_DISCR_THR, 0); end
                1: begin write_reg(REG_ZERO_THR, 38'd50); write_reg(REG_DISCR_THR, '1); end
                2: begin
                    write_reg(REG_ZERO_THR, $urandom_range(0, 5000));
                    write_reg(REG_DISCR_THR, $urandom_range(0, 100000));
                end
                3: begin
                    write_reg(REG_ZERO_THR, {$urandom, $urandom});
                    write_reg(REG_DISCR_THR, $urandom);
                end
                default: begin write_reg(REG_ZERO_THR, 0); write_reg(REG_DISCR_THR, 0); end
            endcase
            if (ph == 4)
                no_idle = 1;
            for (int i = 0; i < 50; i++)
            begin
                if (ph == 0 && i == 10)
                    hold_req = 1;
                send_curve(random_curve());
            end
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
design/ckc_pkg.sv
design/ckc_front.sv
design/ckc_sqrt.sv
design/ckc_klm.sv
design/ckc_serial.sv
design/cubic_klm_coordinates.sv
tb/cubic_klm_coordinates_tb.sv
